// File: sv/caf_pkg.sv
// Package for the caller frequency tracker: sizes, field widths, codes,
// and the table entry type. No dependencies.
`default_nettype none
package caf_pkg;

    // Sizing
    localparam int RING_DEPTH   = 1024;
    localparam int TABLE_DEPTH  = 64;
    localparam int TRACKERS     = 2;
    localparam int HALF_DIVISOR = 2;
    localparam int MAX_READ     = 64;

    localparam int RING_SLOT_W = $clog2(RING_DEPTH);
    localparam int RING_CNT_W  = RING_SLOT_W + 1;
    localparam int TRK_W       = (TRACKERS > 1) ? $clog2(TRACKERS) : 1;
    localparam int RING_ADDR_W = TRK_W + RING_SLOT_W;
    localparam int TBL_IDX_W   = $clog2(TABLE_DEPTH);
    localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);
    localparam int TBL_ADDR_W  = TRK_W + TBL_IDX_W;
    localparam int HALF_MARK   = RING_DEPTH / HALF_DIVISOR;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int CALLER_W = 64;
    localparam int MAXE_W   = 7;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 32;
    localparam int MOVED_W  = 11;
    localparam int CMP_W    = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_RECORD = 2'd0,
        CMD_FETCH  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_RING_FULL  = 3'd1,
        ST_DISABLED   = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_EMPTY      = 3'd4
    } status_t;

    typedef struct packed {
        logic [CALLER_W-1:0] caller;
        logic [COUNT_W-1:0]  count;
    } tbl_entry_t;

    localparam int TBL_W = $bits(tbl_entry_t);

endpackage
`default_nettype wire

// File: sv/caf_ifs.sv
// Handshake channels of the caller frequency tracker: request, result and
// configuration. Depends on caf_pkg.
`default_nettype none
interface caf_req_if;
    logic                         valid;
    logic                         ready;
    logic [caf_pkg::CMD_W-1:0]    cmd;
    logic                         track_select;
    logic [caf_pkg::CALLER_W-1:0] caller;
    logic [caf_pkg::MAXE_W-1:0]   max_entries;

    modport source (output valid, cmd, track_select, caller, max_entries, input ready);
    modport sink   (input valid, cmd, track_select, caller, max_entries, output ready);
endinterface

interface caf_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [caf_pkg::STATUS_W-1:0] status;
    logic                         half_full;
    logic [caf_pkg::CALLER_W-1:0] entry_caller;
    logic [caf_pkg::COUNT_W-1:0]  entry_count;
    logic [caf_pkg::MOVED_W-1:0]  moved;
    logic [caf_pkg::MOVED_W-1:0]  dropped;
    logic                         last;

    modport source (output valid, status, half_full, entry_caller, entry_count, moved,
                    dropped, last, input ready);
    modport sink   (input valid, status, half_full, entry_caller, entry_count, moved,
                    dropped, last, output ready);
endinterface

interface caf_cfg_if;
    logic valid;
    logic ready;
    logic enable;

    modport source (output valid, enable, input ready);
    modport sink   (input valid, enable, output ready);
endinterface
`default_nettype wire

// File: sv/caller_frequency_tracker.sv
// Top level of the caller frequency tracker: command sequencer, ring and
// table memories. Depends on caf_pkg, caf_ifs and caf_ram.
//
// Usage:
//   req: one command per transfer (record, fetch, read) for the tracker
//        picked by track_select. rsp: result transfers, last marks the
//        final one of a command. cfg: writes the enable bit; every write
//        also empties all rings (tables are kept). Write it only when idle.
//   Record: result sits in the output register in the cycle after the
//        transfer; records can follow every cycle while rsp keeps up.
//   Fetch: pops each ring item, scans the table up to its place, then
//        counts a match up or shifts later entries up one place and puts
//        the new entry in; one result.
//   Read: entries are read out from the front, then the remaining entries
//        are moved down to the front of the table.
//   Reset: rings and tables empty, tracking disabled; no clearing pass.
//   Stall: a single output register holds the result; the sequencer waits
//        for it to drain, and req.ready drops until it can take a result.
`default_nettype none
module caller_frequency_tracker (
    input  wire logic  clk,
    input  wire logic  rst_n,
    caf_req_if.sink    req,
    caf_rsp_if.source  rsp,
    caf_cfg_if.sink    cfg
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_F_RRING = 11'b000_0000_0010,
        S_F_RWAIT = 11'b000_0000_0100,
        S_F_SCAN  = 11'b000_0000_1000,
        S_F_SHIFT = 11'b000_0001_0000,
        S_F_PUT   = 11'b000_0010_0000,
        S_F_NEXT  = 11'b000_0100_0000,
        S_F_DONE  = 11'b000_1000_0000,
        S_R_WAIT  = 11'b001_0000_0000,
        S_R_SHIFT = 11'b010_0000_0000,
        S_R_EMPTY = 11'b100_0000_0000
    } state_t;

    localparam int RCW = caf_pkg::RING_CNT_W;
    localparam int OW  = caf_pkg::OCC_W;
    localparam int TW  = caf_pkg::TRK_W;
    localparam int IW  = caf_pkg::TBL_IDX_W;
    localparam int MW  = caf_pkg::MOVED_W;
    localparam int CW  = caf_pkg::CMP_W;

    state_t state_reg, state_next;
    logic            enable_reg, enable_next;
    logic [RCW-1:0]  wcnt_reg [caf_pkg::TRACKERS];
    logic [RCW-1:0]  wcnt_next [caf_pkg::TRACKERS];
    logic [RCW-1:0]  rcnt_reg [caf_pkg::TRACKERS];
    logic [RCW-1:0]  rcnt_next [caf_pkg::TRACKERS];
    logic [OW-1:0]   occ_reg [caf_pkg::TRACKERS];
    logic [OW-1:0]   occ_next [caf_pkg::TRACKERS];
    logic [TW-1:0]   trk_reg, trk_next;
    logic [caf_pkg::CALLER_W-1:0] addr_reg, addr_next;
    logic [OW-1:0]   pos_reg, pos_next;
    logic [OW-1:0]   j_reg, j_next;
    logic [OW-1:0]   k_reg, k_next;
    logic [OW-1:0]   n_reg, n_next;
    logic [RCW-1:0]  remain_reg, remain_next;
    logic [MW-1:0]   moved_reg, moved_next;
    logic [MW-1:0]   lost_reg, lost_next;

    // Output register
    logic                          out_valid_reg;
    logic [caf_pkg::STATUS_W-1:0]  out_status_reg;
    logic                          out_half_reg;
    logic [caf_pkg::CALLER_W-1:0]  out_caller_reg;
    logic [caf_pkg::COUNT_W-1:0]   out_count_reg;
    logic [MW-1:0]                 out_moved_reg;
    logic [MW-1:0]                 out_dropped_reg;
    logic                          out_last_reg;
    logic                          out_load;
    caf_pkg::status_t              ld_status;
    logic                          ld_half;
    logic [caf_pkg::CALLER_W-1:0]  ld_caller;
    logic [caf_pkg::COUNT_W-1:0]   ld_count;
    logic [MW-1:0]                 ld_moved;
    logic [MW-1:0]                 ld_dropped;
    logic                          ld_last;
    logic                          out_free;

    // Memory ports
    logic                            ring_we, ring_re;
    logic [caf_pkg::RING_ADDR_W-1:0] ring_wa, ring_ra;
    logic [caf_pkg::CALLER_W-1:0]    ring_rdata;
    logic                            tbl_we, tbl_re;
    logic [caf_pkg::TBL_ADDR_W-1:0]  tbl_wa, tbl_ra;
    caf_pkg::tbl_entry_t             tbl_wd, tbl_rdata;

    // Decoded request
    logic             req_fire, cfg_fire;
    logic [TW-1:0]    req_trk;
    logic [RCW-1:0]   req_len;
    logic [RCW-1:0]   req_len_inc;
    logic [CW-1:0]    req_n;
    logic [OW-1:0]    occ_cur;
    logic [OW-1:0]    occ_req;

    // Shared insertion decision
    logic             ins_go;
    logic [OW-1:0]    ins_pos;
    logic [caf_pkg::CALLER_W-1:0] fetch_addr;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign cfg.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign req_trk   = (caf_pkg::TRACKERS == 1) ? '0 : TW'(req.track_select);
    assign occ_cur   = occ_reg[trk_reg];
    assign occ_req   = occ_reg[req_trk];
    assign req_len   = wcnt_reg[req_trk] - rcnt_reg[req_trk];
    assign req_len_inc = req_len + RCW'(1);
    assign fetch_addr  = (state_reg == S_F_RWAIT) ? ring_rdata : addr_reg;

    // Number of entries a read takes: min(max_entries, occupancy, MAX_READ)
    always_comb
    begin
        req_n = CW'(req.max_entries);
        if (CW'(occ_req) < req_n)
        begin
            req_n = CW'(occ_req);
        end
        if (CW'(caf_pkg::MAX_READ) < req_n)
        begin
            req_n = CW'(caf_pkg::MAX_READ);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        enable_next = enable_reg;
        wcnt_next   = wcnt_reg;
        rcnt_next   = rcnt_reg;
        occ_next    = occ_reg;
        trk_next    = trk_reg;
        addr_next   = addr_reg;
        pos_next    = pos_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        n_next      = n_reg;
        remain_next = remain_reg;
        moved_next  = moved_reg;
        lost_next   = lost_reg;
        out_load    = 1'b0;
        ld_status   = caf_pkg::ST_OK;
        ld_half     = 1'b0;
        ld_caller   = '0;
        ld_count    = '0;
        ld_moved    = '0;
        ld_dropped  = '0;
        ld_last     = 1'b1;
        ring_we     = 1'b0;
        ring_wa     = {req_trk, wcnt_reg[req_trk][caf_pkg::RING_SLOT_W-1:0]};
        ring_re     = 1'b0;
        ring_ra     = {trk_reg, rcnt_reg[trk_reg][caf_pkg::RING_SLOT_W-1:0]};
        tbl_we      = 1'b0;
        tbl_wa      = {trk_reg, pos_reg[IW-1:0]};
        tbl_wd      = '{caller: fetch_addr, count: caf_pkg::COUNT_W'(1)};
        tbl_re      = 1'b0;
        tbl_ra      = {trk_reg, IW'(0)};
        ins_go      = 1'b0;
        ins_pos     = pos_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                begin
                    enable_next = cfg.enable;
                    for (int t = 0; t < caf_pkg::TRACKERS; t++)
                    begin
                        wcnt_next[t] = '0;
                        rcnt_next[t] = '0;
                    end
                end
                if (req_fire)
                begin
                    trk_next = req_trk;
                    case (caf_pkg::cmd_t'(req.cmd))
                        caf_pkg::CMD_RECORD:
                        begin
                            out_load = 1'b1;
                            if (!enable_reg)
                            begin
                                ld_status = caf_pkg::ST_DISABLED;
                            end
                            else if (req_len[RCW-1])
                            begin
                                ld_status = caf_pkg::ST_RING_FULL;
                                ld_half   = 1'b1;
                            end
                            else
                            begin
                                ring_we   = 1'b1;
                                wcnt_next[req_trk] = wcnt_reg[req_trk] + RCW'(1);
                                ld_half   = (req_len_inc >= RCW'(caf_pkg::HALF_MARK));
                            end
                        end
                        caf_pkg::CMD_FETCH:
                        begin
                            remain_next = req_len;
                            moved_next  = MW'(req_len);
                            lost_next   = '0;
                            state_next  = (req_len == '0) ? S_F_DONE : S_F_RRING;
                        end
                        caf_pkg::CMD_READ:
                        begin
                            n_next = OW'(req_n);
                            k_next = '0;
                            if (req_n == '0)
                            begin
                                state_next = S_R_EMPTY;
                            end
                            else
                            begin
                                tbl_re     = 1'b1;
                                tbl_ra     = {req_trk, IW'(0)};
                                state_next = S_R_WAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Pop one ring item
            S_F_RRING:
            begin
                ring_re = 1'b1;
                rcnt_next[trk_reg] = rcnt_reg[trk_reg] + RCW'(1);
                state_next = S_F_RWAIT;
            end

            S_F_RWAIT:
            begin
                addr_next = ring_rdata;
                pos_next  = '0;
                if (occ_cur == '0)
                begin
                    ins_go  = 1'b1;
                    ins_pos = '0;
                end
                else
                begin
                    tbl_re     = 1'b1;
                    tbl_ra     = {trk_reg, IW'(0)};
                    state_next = S_F_SCAN;
                end
            end

            // Linear search of the sorted table
            S_F_SCAN:
            begin
                if (tbl_rdata.caller < addr_reg)
                begin
                    if ((pos_reg + OW'(1)) < occ_cur)
                    begin
                        pos_next = pos_reg + OW'(1);
                        tbl_re   = 1'b1;
                        tbl_ra   = {trk_reg, IW'(pos_reg + OW'(1))};
                    end
                    else
                    begin
                        ins_go  = 1'b1;
                        ins_pos = occ_cur;
                    end
                end
                else if (tbl_rdata.caller == addr_reg)
                begin
                    tbl_we       = 1'b1;
                    tbl_wd.count = (&tbl_rdata.count) ? tbl_rdata.count
                                                      : tbl_rdata.count + 1'b1;
                    state_next   = S_F_NEXT;
                end
                else
                begin
                    ins_go  = 1'b1;
                    ins_pos = pos_reg;
                end
            end

            // Move entries up one place, top first
            S_F_SHIFT:
            begin
                tbl_we = 1'b1;
                tbl_wa = {trk_reg, IW'(j_reg + OW'(1))};
                tbl_wd = tbl_rdata;
                if (j_reg == pos_reg)
                begin
                    state_next = S_F_PUT;
                end
                else
                begin
                    j_next = j_reg - OW'(1);
                    tbl_re = 1'b1;
                    tbl_ra = {trk_reg, IW'(j_reg - OW'(1))};
                end
            end

            S_F_PUT:
            begin
                tbl_we = 1'b1;
                occ_next[trk_reg] = occ_cur + OW'(1);
                state_next = S_F_NEXT;
            end

            S_F_NEXT:
            begin
                remain_next = remain_reg - RCW'(1);
                state_next  = (remain_reg == RCW'(1)) ? S_F_DONE : S_F_RRING;
            end

            S_F_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ld_status  = (lost_reg != '0) ? caf_pkg::ST_TABLE_FULL : caf_pkg::ST_OK;
                    ld_moved   = moved_reg;
                    ld_dropped = lost_reg;
                    state_next = S_IDLE;
                end
            end

            // Emit entries from the front
            S_R_WAIT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    ld_caller = tbl_rdata.caller;
                    ld_count  = tbl_rdata.count;
                    ld_last   = ((k_reg + OW'(1)) == n_reg);
                    if ((k_reg + OW'(1)) == n_reg)
                    begin
                        if (n_reg < occ_cur)
                        begin
                            j_next     = n_reg;
                            tbl_re     = 1'b1;
                            tbl_ra     = {trk_reg, IW'(n_reg)};
                            state_next = S_R_SHIFT;
                        end
                        else
                        begin
                            occ_next[trk_reg] = occ_cur - n_reg;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + OW'(1);
                        tbl_re = 1'b1;
                        tbl_ra = {trk_reg, IW'(k_reg + OW'(1))};
                    end
                end
            end

            // Move remaining entries down to the front
            S_R_SHIFT:
            begin
                tbl_we = 1'b1;
                tbl_wa = {trk_reg, IW'(j_reg - n_reg)};
                tbl_wd = tbl_rdata;
                if ((j_reg + OW'(1)) < occ_cur)
                begin
                    j_next = j_reg + OW'(1);
                    tbl_re = 1'b1;
                    tbl_ra = {trk_reg, IW'(j_reg + OW'(1))};
                end
                else
                begin
                    occ_next[trk_reg] = occ_cur - n_reg;
                    state_next = S_IDLE;
                end
            end

            S_R_EMPTY:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ld_status  = caf_pkg::ST_EMPTY;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Insert a new address at ins_pos, or drop it when full
        if (ins_go)
        begin
            pos_next = ins_pos;
            if (occ_cur == OW'(caf_pkg::TABLE_DEPTH))
            begin
                lost_next  = lost_reg + MW'(1);
                state_next = S_F_NEXT;
            end
            else if (ins_pos == occ_cur)
            begin
                tbl_we = 1'b1;
                tbl_wa = {trk_reg, IW'(ins_pos)};
                occ_next[trk_reg] = occ_cur + OW'(1);
                state_next = S_F_NEXT;
            end
            else
            begin
                j_next     = occ_cur - OW'(1);
                tbl_re     = 1'b1;
                tbl_ra     = {trk_reg, IW'(occ_cur - OW'(1))};
                state_next = S_F_SHIFT;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < caf_pkg::TRACKERS; t++)
            begin
                wcnt_reg[t] <= '0;
                rcnt_reg[t] <= '0;
                occ_reg[t]  <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            enable_reg <= enable_next;
            wcnt_reg   <= wcnt_next;
            rcnt_reg   <= rcnt_next;
            occ_reg    <= occ_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        trk_reg    <= trk_next;
        addr_reg   <= addr_next;
        pos_reg    <= pos_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        n_reg      <= n_next;
        remain_reg <= remain_next;
        moved_reg  <= moved_next;
        lost_reg   <= lost_next;
        if (out_load)
        begin
            out_status_reg  <= ld_status;
            out_half_reg    <= ld_half;
            out_caller_reg  <= ld_caller;
            out_count_reg   <= ld_count;
            out_moved_reg   <= ld_moved;
            out_dropped_reg <= ld_dropped;
            out_last_reg    <= ld_last;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.half_full    = out_half_reg;
    assign rsp.entry_caller = out_caller_reg;
    assign rsp.entry_count  = out_count_reg;
    assign rsp.moved        = out_moved_reg;
    assign rsp.dropped      = out_dropped_reg;
    assign rsp.last         = out_last_reg;

    // Ring store: all trackers in one memory
    caf_ram #(
        .WIDTH (caf_pkg::CALLER_W),
        .DEPTH (caf_pkg::TRACKERS * caf_pkg::RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (ring_wa),
        .wr_data (req.caller),
        .rd_en   (ring_re),
        .rd_addr (ring_ra),
        .rd_data (ring_rdata)
    );

    // Sorted count table: all trackers in one memory
    caf_ram #(
        .WIDTH (caf_pkg::TBL_W),
        .DEPTH (caf_pkg::TRACKERS * caf_pkg::TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_wa),
        .wr_data (tbl_wd),
        .rd_en   (tbl_re),
        .rd_addr (tbl_ra),
        .rd_data (tbl_rdata)
    );

endmodule
`default_nettype wire

// File: sv/caf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read
// data that holds until the next read. No dependencies.
`default_nettype none
module caf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: sv/caf_checker.sv
// Port-level checks for the caller frequency tracker, bound to the top
// level. Depends on caf_pkg and caller_frequency_tracker.
`default_nettype none
module caf_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_ready,
    input wire logic [caf_pkg::CMD_W-1:0]    req_cmd,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_ready,
    input wire logic [caf_pkg::STATUS_W-1:0] rsp_status,
    input wire logic [caf_pkg::COUNT_W-1:0]  rsp_count,
    input wire logic                         rsp_last,
    input wire logic                         cfg_ready
);

    // A pending result stays until its transfer
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before transfer");

    // Stalled result keeps its status and last flag
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_last))
        else $error("result payload changed while stalled");

    // Record gives its single result right after the transfer
    a_record_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_cmd == caf_pkg::CMD_RECORD
        |=> rsp_valid && rsp_last)
        else $error("record result missing");

    // Empty-read status is a lone result with a zero entry count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == caf_pkg::ST_EMPTY |-> rsp_last && rsp_count == '0)
        else $error("bad empty-read result");

    // Commands are taken only when configuration could be taken too
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> cfg_ready)
        else $error("request ready while busy");

endmodule

bind caller_frequency_tracker caf_checker u_caf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_cmd    (req.cmd),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_count  (rsp.entry_count),
    .rsp_last   (rsp.last),
    .cfg_ready  (cfg.ready)
);
`default_nettype wire
